[src/nfl_pkg.sv]
// Shared types and constants for the node pool free-list manager.
// Used by the controller, the datapath and the top level; no dependencies.
package nfl_pkg;

  // Default pool size and fixed field widths
  localparam int POOL_NODES_DEF = 128;
  localparam int OP_W           = 2;
  localparam int NODE_W         = 7;
  localparam int RESULT_W       = 8;
  localparam int STATUS_W       = 2;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NOSUCC = 2'd2
  } status_t;

  // RAM address source
  typedef enum logic [2:0] {
    ASEL_HEAD  = 3'd0,
    ASEL_NODE  = 3'd1,
    ASEL_T1    = 3'd2,
    ASEL_RDATA = 3'd3,
    ASEL_SWEEP = 3'd4
  } asel_t;

  // RAM write data source
  typedef enum logic [1:0] {
    WSEL_NULL  = 2'd0,
    WSEL_HEAD  = 2'd1,
    WSEL_RDATA = 2'd2,
    WSEL_SWEEP = 2'd3
  } wsel_t;

  // Free-list head update
  typedef enum logic [1:0] {
    HSEL_HOLD  = 2'd0,
    HSEL_RDATA = 2'd1,
    HSEL_NODE  = 2'd2,
    HSEL_T1    = 2'd3
  } hsel_t;

  // Result node source
  typedef enum logic [1:0] {
    RSEL_NULL = 2'd0,
    RSEL_HEAD = 2'd1,
    RSEL_NODE = 2'd2,
    RSEL_T1   = 2'd3
  } rsel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch_in;
    logic    mem_en;
    logic    mem_we;
    asel_t   asel;
    wsel_t   wsel;
    hsel_t   hsel;
    logic    cap_t1;
    logic    res_load;
    rsel_t   rsel;
    status_t status;
    logic    sweep_inc;
    logic    out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_node_ok;
    logic head_null;
    logic rd_null;
    logic sweep_last;
  } sts_t;

endpackage

[src/nfl_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module nfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[src/nfl_ctrl.sv]
// Sequencer for the free-list manager: steps each request through the link RAM.
// Depends on nfl_pkg for the command and status structs and the codes.
module nfl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [nfl_pkg::OP_W-1:0] in_op,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  nfl_pkg::sts_t        sts,
  output nfl_pkg::cmd_t        cmd
);

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_A_RD  = 14'b00000000000100,
    S_A_WR  = 14'b00000000001000,
    S_F_WR  = 14'b00000000010000,
    S_I_RD1 = 14'b00000000100000,
    S_I_RD2 = 14'b00000001000000,
    S_I_WR1 = 14'b00000010000000,
    S_I_WR2 = 14'b00000100000000,
    S_D_RD1 = 14'b00001000000000,
    S_D_CHK = 14'b00010000000000,
    S_D_WR1 = 14'b00100000000000,
    S_D_WR2 = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.asel  = nfl_pkg::ASEL_HEAD;
    cmd.wsel  = nfl_pkg::WSEL_NULL;
    cmd.hsel  = nfl_pkg::HSEL_HOLD;
    cmd.rsel  = nfl_pkg::RSEL_NULL;
    cmd.status = nfl_pkg::ST_OK;

    case (state_r)
      S_INIT: begin
        cmd.mem_en    = 1'b1;
        cmd.mem_we    = 1'b1;
        cmd.asel      = nfl_pkg::ASEL_SWEEP;
        cmd.wsel      = nfl_pkg::WSEL_SWEEP;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_A_RD: begin
        cmd.mem_en = 1'b1;
        cmd.asel   = nfl_pkg::ASEL_HEAD;
        state_nxt  = S_A_WR;
      end
      S_A_WR: begin
        // head moves to its successor, popped node gets a null link
        cmd.mem_en   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.asel     = nfl_pkg::ASEL_HEAD;
        cmd.wsel     = nfl_pkg::WSEL_NULL;
        cmd.hsel     = nfl_pkg::HSEL_RDATA;
        cmd.res_load = 1'b1;
        cmd.rsel     = nfl_pkg::RSEL_HEAD;
        state_nxt    = S_RESP;
      end
      S_F_WR: begin
        cmd.mem_en   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.asel     = nfl_pkg::ASEL_NODE;
        cmd.wsel     = nfl_pkg::WSEL_HEAD;
        cmd.hsel     = nfl_pkg::HSEL_NODE;
        cmd.res_load = 1'b1;
        cmd.rsel     = nfl_pkg::RSEL_NODE;
        state_nxt    = S_RESP;
      end
      S_I_RD1: begin
        cmd.mem_en = 1'b1;
        cmd.asel   = nfl_pkg::ASEL_HEAD;
        state_nxt  = S_I_RD2;
      end
      S_I_RD2: begin
        // keep the new head, fetch the successor of the anchor node
        cmd.cap_t1 = 1'b1;
        cmd.mem_en = 1'b1;
        cmd.asel   = nfl_pkg::ASEL_NODE;
        state_nxt  = S_I_WR1;
      end
      S_I_WR1: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.asel   = nfl_pkg::ASEL_HEAD;
        cmd.wsel   = nfl_pkg::WSEL_RDATA;
        state_nxt  = S_I_WR2;
      end
      S_I_WR2: begin
        cmd.mem_en   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.asel     = nfl_pkg::ASEL_NODE;
        cmd.wsel     = nfl_pkg::WSEL_HEAD;
        cmd.hsel     = nfl_pkg::HSEL_T1;
        cmd.res_load = 1'b1;
        cmd.rsel     = nfl_pkg::RSEL_HEAD;
        state_nxt    = S_RESP;
      end
      S_D_RD1: begin
        cmd.mem_en = 1'b1;
        cmd.asel   = nfl_pkg::ASEL_NODE;
        state_nxt  = S_D_CHK;
      end
      S_D_CHK: begin
        cmd.cap_t1 = 1'b1;
        if (sts.rd_null) begin
          cmd.res_load = 1'b1;
          cmd.rsel     = nfl_pkg::RSEL_NULL;
          cmd.status   = nfl_pkg::ST_NOSUCC;
          state_nxt    = S_RESP;
        end else begin
          // fetch the successor of the node being removed
          cmd.mem_en = 1'b1;
          cmd.asel   = nfl_pkg::ASEL_RDATA;
          state_nxt  = S_D_WR1;
        end
      end
      S_D_WR1: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.asel   = nfl_pkg::ASEL_NODE;
        cmd.wsel   = nfl_pkg::WSEL_RDATA;
        state_nxt  = S_D_WR2;
      end
      S_D_WR2: begin
        cmd.mem_en   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.asel     = nfl_pkg::ASEL_T1;
        cmd.wsel     = nfl_pkg::WSEL_HEAD;
        cmd.hsel     = nfl_pkg::HSEL_T1;
        cmd.res_load = 1'b1;
        cmd.rsel     = nfl_pkg::RSEL_T1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Accept a word from idle or straight after handing on a result
    if (accept) begin
      cmd.latch_in = 1'b1;
      case (nfl_pkg::op_t'(in_op))
        nfl_pkg::OP_ALLOC: begin
          if (sts.head_null) begin
            cmd.res_load = 1'b1;
            cmd.status   = nfl_pkg::ST_EMPTY;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_A_RD;
          end
        end
        nfl_pkg::OP_FREE: begin
          if (!sts.in_node_ok) begin
            cmd.res_load = 1'b1;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_F_WR;
          end
        end
        nfl_pkg::OP_INSERT: begin
          if (!sts.in_node_ok) begin
            cmd.res_load = 1'b1;
            cmd.status   = nfl_pkg::ST_NOSUCC;
            state_nxt    = S_RESP;
          end else if (sts.head_null) begin
            cmd.res_load = 1'b1;
            cmd.status   = nfl_pkg::ST_EMPTY;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_I_RD1;
          end
        end
        default: begin
          if (!sts.in_node_ok) begin
            cmd.res_load = 1'b1;
            cmd.status   = nfl_pkg::ST_NOSUCC;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_D_RD1;
          end
        end
      endcase
    end
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result is never loaded over one that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending word");

  // Output valid only rises through a result load
  a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("output valid rose without a load");

  // No request is taken while the link table is being initialised
  a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !cmd.latch_in && !cmd.out_load)
    else $error("request handled during link table sweep");
`endif

endmodule

[src/nfl_dpath.sv]
// Datapath for the free-list manager: link RAM, free-list head, temporaries
// and result registers. Depends on nfl_pkg and nfl_ram.
module nfl_dpath #(
  parameter int POOL_NODES = nfl_pkg::POOL_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [nfl_pkg::NODE_W-1:0]   in_node,
  input  nfl_pkg::cmd_t                cmd,
  output nfl_pkg::sts_t                sts,
  output logic [nfl_pkg::RESULT_W-1:0] out_res,
  output logic [nfl_pkg::STATUS_W-1:0] out_st
);

  localparam int AW = $clog2(POOL_NODES);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int RW = nfl_pkg::RESULT_W;
  localparam logic [LW-1:0] NULL_IDX = LW'(POOL_NODES);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_NODES - 1);

  logic [nfl_pkg::NODE_W-1:0]   node_r;
  logic [LW-1:0]                head_r, head_nxt;
  logic [LW-1:0]                t1_r;
  logic [LW-1:0]                res_r, res_nxt;
  logic [nfl_pkg::STATUS_W-1:0] st_r;
  logic [RW-1:0]                out_res_r;
  logic [nfl_pkg::STATUS_W-1:0] out_st_r;
  logic [AW-1:0]                sweep_r;

  logic [AW-1:0] ram_addr;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] rdata_s;

  nfl_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk   (clk),
    .en    (cmd.mem_en),
    .we    (cmd.mem_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Any stored index beyond the pool reads as null
  assign rdata_s = (ram_rdata >= NULL_IDX) ? NULL_IDX : ram_rdata;

  // Status back to the sequencer
  assign sts.in_node_ok = 32'(in_node) < 32'(POOL_NODES);
  assign sts.head_null  = (head_r == NULL_IDX);
  assign sts.rd_null    = (rdata_s == NULL_IDX);
  assign sts.sweep_last = (sweep_r == LAST_IDX);

  // RAM address select
  always_comb begin
    case (cmd.asel)
      nfl_pkg::ASEL_HEAD:  ram_addr = AW'(head_r);
      nfl_pkg::ASEL_NODE:  ram_addr = AW'(node_r);
      nfl_pkg::ASEL_T1:    ram_addr = AW'(t1_r);
      nfl_pkg::ASEL_RDATA: ram_addr = AW'(rdata_s);
      nfl_pkg::ASEL_SWEEP: ram_addr = sweep_r;
      default:             ram_addr = '0;
    endcase
  end

  // RAM write data select
  always_comb begin
    case (cmd.wsel)
      nfl_pkg::WSEL_NULL:  ram_wdata = NULL_IDX;
      nfl_pkg::WSEL_HEAD:  ram_wdata = head_r;
      nfl_pkg::WSEL_RDATA: ram_wdata = rdata_s;
      nfl_pkg::WSEL_SWEEP: ram_wdata = LW'(sweep_r) + LW'(1);
      default:             ram_wdata = NULL_IDX;
    endcase
  end

  // Free-list head update
  always_comb begin
    case (cmd.hsel)
      nfl_pkg::HSEL_HOLD:  head_nxt = head_r;
      nfl_pkg::HSEL_RDATA: head_nxt = rdata_s;
      nfl_pkg::HSEL_NODE:  head_nxt = LW'(node_r);
      nfl_pkg::HSEL_T1:    head_nxt = t1_r;
      default:             head_nxt = head_r;
    endcase
  end

  // Result node select
  always_comb begin
    case (cmd.rsel)
      nfl_pkg::RSEL_NULL: res_nxt = NULL_IDX;
      nfl_pkg::RSEL_HEAD: res_nxt = head_r;
      nfl_pkg::RSEL_NODE: res_nxt = LW'(node_r);
      nfl_pkg::RSEL_T1:   res_nxt = t1_r;
      default:            res_nxt = NULL_IDX;
    endcase
  end

  // Control state: head and init sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      sweep_r <= '0;
    end else begin
      head_r <= head_nxt;
      if (cmd.sweep_inc) begin
        sweep_r <= sweep_r + AW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      node_r <= in_node;
    end
    if (cmd.cap_t1) begin
      t1_r <= rdata_s;
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
      st_r  <= cmd.status;
    end
    if (cmd.out_load) begin
      out_res_r <= RW'(res_r);
      out_st_r  <= st_r;
    end
  end

  assign out_res = out_res_r;
  assign out_st  = out_st_r;

`ifndef SYNTHESIS
  // Links written to the table are always in range or null
  a_wdata_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_en && cmd.mem_we) |-> (ram_wdata <= NULL_IDX))
    else $error("out of range link written");

  // The head only moves together with a link table write
  a_head_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (head_r != $past(head_r))) |-> $past(cmd.mem_we))
    else $error("free-list head moved without a link write");

  // The head never holds an index beyond null
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (head_r <= NULL_IDX))
    else $error("free-list head out of range");
`endif

endmodule

[src/node_pool_free_list.sv]
// Top level of the node pool free-list manager.
// Depends on nfl_pkg, nfl_ctrl, nfl_dpath (which holds nfl_ram).
//
// Keeps a pool of POOL_NODES linked nodes as a next-index table in one
// single-port RAM plus a free-list head; index POOL_NODES is null. Each input
// word carries an operation in in_tuser and a node index in in_tdata, and
// gives one output word: the node index in out_tdata and a status in
// out_tuser. After reset the block sweeps the table, writing one entry a
// cycle, and takes no word until the sweep is done. Free writes a link;
// allocate reads and writes the head; insert-after reads the head and the
// node, then writes both; delete-next reads the node and, if any, its
// successor and then writes both; a refused request (empty pool, bad node)
// goes straight to the result. The next word is accepted while the
// previous result waits in the output register.
module node_pool_free_list #(
  parameter int POOL_NODES = nfl_pkg::POOL_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] node
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] result_node
  output logic [1:0]  out_tuser   // [1:0] status
);

  nfl_pkg::cmd_t cmd;
  nfl_pkg::sts_t sts;
  logic [nfl_pkg::RESULT_W-1:0] out_res;
  logic [nfl_pkg::STATUS_W-1:0] out_st;

  nfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nfl_dpath #(
    .POOL_NODES (POOL_NODES)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_node (in_tdata[nfl_pkg::NODE_W-1:0]),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res),
    .out_st  (out_st)
  );

  // Pack the result word
  assign out_tdata = out_res;
  assign out_tuser = out_st;

endmodule
